// ===== hw/rtl/bcd_clock_seven_segment_scanner_macros.svh =====
// assertion macros shared by the checker of the clock display scanner
// no dependencies; include by bare file name
`ifndef BCD_CLOCK_SEVEN_SEGMENT_SCANNER_MACROS_SVH
`define BCD_CLOCK_SEVEN_SEGMENT_SCANNER_MACROS_SVH

// condition and consequence in the same cycle
`define BCDCLK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequence in the cycle after the condition
`define BCDCLK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bcdclk_pkg.sv =====
// types, codes and constants of the clock display scanner
// no dependencies; imported by every other file of the block but the macro header
package bcdclk_pkg;

    // input commands
    localparam logic [1:0] CMD_READING = 2'd0;
    localparam logic [1:0] CMD_ADJUST  = 2'd1;
    localparam logic [1:0] CMD_SCAN    = 2'd2;
    localparam logic [1:0] CMD_LAMP    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_SCAN  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_LAMP  = 2'd2;

    // clock register addresses
    localparam logic [1:0] ADDR_SECONDS = 2'd0;
    localparam logic [1:0] ADDR_MINUTES = 2'd1;
    localparam logic [1:0] ADDR_HOURS   = 2'd2;

    // queued job kinds
    localparam logic [1:0] JOB_ADJUST = 2'd0;
    localparam logic [1:0] JOB_SCAN   = 2'd1;
    localparam logic [1:0] JOB_LAMP   = 2'd2;

    // segment patterns, active low
    localparam logic [7:0] PAT_BLANK = 8'hFF;
    localparam logic [7:0] PAT_ZERO  = 8'h0A;
    localparam logic [7:0] DOT_MASK  = 8'hF7;
    localparam logic [7:0] SEG_TABLE [10] = '{
        8'h0A, 8'h7B, 8'h4C, 8'h68, 8'h39, 8'hA8, 8'h88, 8'h7A, 8'h08, 8'h28
    };

    // job queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] minutes_reg;
        logic [7:0] hours_reg;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] segments;
        logic [2:0] digit_select;
        logic [1:0] write_address;
        logic [7:0] write_data;
        logic       lamp_on;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [1:0] op;
        logic       wrap;
        logic [7:0] hour_bcd;
        logic [7:0] min_bcd;
        logic [7:0] segments;
        logic [2:0] digit_sel;
        logic       lamp;
    } t_job;

endpackage

// ===== hw/rtl/bcdclk_if.sv =====
// valid/ready channels of the clock display scanner, input and result side
// depends on bcdclk_pkg for the payload types
interface bcdclk_in_if import bcdclk_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface bcdclk_out_if import bcdclk_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/bcdclk_queue.sv =====
// short job queue between the front and back parts
// depends on bcdclk_pkg for the job type and depth
module bcdclk_queue import bcdclk_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    t_job                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10: r_count <= r_count + (QUEUE_AW+1)'(1);
                2'b01: r_count <= r_count - (QUEUE_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/bcdclk_front.sv =====
// front part: accepts commands, keeps display state, computes adjust values
// depends on bcdclk_pkg and bcdclk_if; feeds jobs to bcdclk_queue
module bcdclk_front import bcdclk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcdclk_in_if.sink   i_in,
    input  logic        i_q_full,
    output logic        o_q_push,
    output t_job        o_q_job
);

    logic [7:0] r_pat [4];
    logic [1:0] r_scan;
    logic       r_lamp;

    logic       accept;
    logic [7:0] mr;
    logic [7:0] hr;
    logic [5:0] h_val;
    logic [7:0] m_val;
    logic       wrap;
    logic [5:0] new_m;
    logic [5:0] h_inc;
    logic [7:0] hour_bcd;
    logic [7:0] min_bcd;
    logic [7:0] src_m;
    logic [7:0] src_h;
    logic [7:0] n_pat [4];
    logic [1:0] pos;

    function automatic logic [7:0] seg_of(input logic [3:0] nib);
        logic [7:0] pat;
        begin
            if (nib > 4'd9) begin
                pat = PAT_BLANK;
            end else begin
                pat = SEG_TABLE[nib];
            end
            return pat;
        end
    endfunction

    // value is below sixty
    function automatic logic [7:0] to_bcd(input logic [5:0] v);
        logic [2:0] t;
        logic [5:0] u;
        begin
            if (v >= 6'd50) begin
                t = 3'd5;
            end else if (v >= 6'd40) begin
                t = 3'd4;
            end else if (v >= 6'd30) begin
                t = 3'd3;
            end else if (v >= 6'd20) begin
                t = 3'd2;
            end else if (v >= 6'd10) begin
                t = 3'd1;
            end else begin
                t = 3'd0;
            end
            u = v - 6'(t) * 6'd10;
            return {1'b0, t, u[3:0]};
        end
    endfunction

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_q_push   = accept && (i_in.item.command != CMD_READING);

    assign mr = i_in.item.minutes_reg;
    assign hr = i_in.item.hours_reg;

    // nibbles above nine still count as tens*10 + units
    assign h_val = 6'(hr[5:4]) * 6'd10 + 6'(hr[3:0]);
    assign m_val = 8'(mr[7:4]) * 8'd10 + 8'(mr[3:0]);
    assign wrap  = (m_val >= 8'd59);
    assign new_m = wrap ? 6'd0 : 6'(m_val + 8'd1);
    assign h_inc = (h_val >= 6'd23) ? 6'd0 : h_val + 6'd1;

    assign hour_bcd = to_bcd(h_inc);
    assign min_bcd  = to_bcd(new_m);

    // adjust refreshes the patterns from the written values
    assign src_m = (i_in.item.command == CMD_ADJUST) ? min_bcd : mr;
    assign src_h = (i_in.item.command == CMD_ADJUST && wrap) ? hour_bcd : hr;

    assign n_pat[0] = seg_of({2'b00, src_h[5:4]});
    assign n_pat[1] = seg_of(src_h[3:0]) & DOT_MASK;
    assign n_pat[2] = seg_of({1'b0, src_m[6:4]});
    assign n_pat[3] = seg_of(src_m[3:0]);

    // a zero in the leading digit is skipped
    assign pos = (r_scan == 2'd0 && r_pat[0] == PAT_ZERO) ? 2'd1 : r_scan;

    always_comb begin
        o_q_job      = '0;
        o_q_job.lamp = r_lamp;
        unique case (i_in.item.command)
            CMD_READING: begin
                o_q_job.op = JOB_ADJUST;
            end
            CMD_ADJUST: begin
                o_q_job.op       = JOB_ADJUST;
                o_q_job.wrap     = wrap;
                o_q_job.hour_bcd = hour_bcd;
                o_q_job.min_bcd  = min_bcd;
            end
            CMD_SCAN: begin
                o_q_job.op        = JOB_SCAN;
                o_q_job.segments  = r_pat[pos];
                o_q_job.digit_sel = 3'(pos) + 3'd1;
            end
            CMD_LAMP: begin
                o_q_job.op   = JOB_LAMP;
                o_q_job.lamp = !r_lamp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '{default: 8'h00};
            r_scan <= 2'd0;
            r_lamp <= 1'b0;
        end else if (accept) begin
            unique case (i_in.item.command)
                CMD_READING, CMD_ADJUST: begin
                    r_pat <= n_pat;
                end
                CMD_SCAN: begin
                    r_scan <= pos + 2'd1;
                end
                CMD_LAMP: begin
                    r_lamp <= !r_lamp;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/bcdclk_back.sv =====
// back part: expands queued jobs into result words behind an output register
// depends on bcdclk_pkg and bcdclk_if; drains bcdclk_queue
module bcdclk_back import bcdclk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_job         i_q_job,
    output logic         o_q_pop,
    bcdclk_out_if.source o_out
);

    localparam logic [1:0] STEP_HOURS   = 2'd0;
    localparam logic [1:0] STEP_SECONDS = 2'd1;
    localparam logic [1:0] STEP_MINUTES = 2'd2;

    t_job      r_cur;
    logic      r_cur_valid;
    logic [1:0] r_step;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      cur_last;
    logic      emit;
    t_out_item res;

    assign out_free = !r_out_valid || o_out.ready;
    assign cur_last = (r_cur.op != JOB_ADJUST) || (r_step == STEP_MINUTES);
    assign emit     = r_cur_valid && out_free;
    assign o_q_pop  = i_q_valid && (!r_cur_valid || (emit && cur_last));

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out_item;

    always_comb begin
        res         = '0;
        res.lamp_on = r_cur.lamp;
        res.last    = cur_last;
        unique case (r_cur.op)
            JOB_ADJUST: begin
                res.kind = KIND_WRITE;
                unique case (r_step)
                    STEP_HOURS: begin
                        res.write_address = ADDR_HOURS;
                        res.write_data    = r_cur.hour_bcd;
                    end
                    STEP_SECONDS: begin
                        res.write_address = ADDR_SECONDS;
                    end
                    STEP_MINUTES: begin
                        res.write_address = ADDR_MINUTES;
                        res.write_data    = r_cur.min_bcd;
                    end
                    default: begin
                        res.write_address = ADDR_SECONDS;
                    end
                endcase
            end
            JOB_SCAN: begin
                res.kind         = KIND_SCAN;
                res.segments     = r_cur.segments;
                res.digit_select = r_cur.digit_sel;
            end
            JOB_LAMP: begin
                res.kind = KIND_LAMP;
            end
            default: begin
                res.kind = KIND_LAMP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cur <= i_q_job;
        end
        if (emit) begin
            r_out_item <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_step      <= STEP_HOURS;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_q_pop) begin
                r_cur_valid <= 1'b1;
                // without a wrap the hours write is left out
                r_step <= (i_q_job.op == JOB_ADJUST && !i_q_job.wrap) ?
                          STEP_SECONDS : STEP_HOURS;
            end else if (emit) begin
                if (cur_last) begin
                    r_cur_valid <= 1'b0;
                end else begin
                    r_step <= r_step + 2'd1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/bcd_clock_seven_segment_scanner.sv =====
// each job passes the queue and the current-job register before the output register
// throughput: one input word per cycle while the two-entry job queue has room;
// one result word per cycle through the output register while its ready is high;
// an adjust gives two or three words, a scan or lamp toggle one, a reading none
// reset (synchronous, active low): patterns all lit, scan at digit 1, lamp off,
// queue and output empty
module bcd_clock_seven_segment_scanner import bcdclk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bcdclk_in_if.sink    i_in,
    bcdclk_out_if.source o_out
);

    logic q_push;
    t_job q_job;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job q_head;

    bcdclk_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_job)
    );

    bcdclk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_head)
    );

    bcdclk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_job   (q_head),
        .o_q_pop   (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== hw/rtl/bcdclk_checker.sv =====
// result-side checks of the clock display scanner, bound to the top level
// depends on bcdclk_pkg and the assertion macro header
`include "bcd_clock_seven_segment_scanner_macros.svh"

module bcdclk_checker import bcdclk_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_item
);

    logic take;
    logic is_write;
    logic wr_hours;
    logic wr_seconds;
    logic wr_minutes;
    logic scan_ok;

    assign take       = i_out_valid && i_out_ready;
    assign is_write   = i_out_valid && (i_out_item.kind == KIND_WRITE);
    assign wr_hours   = is_write && (i_out_item.write_address == ADDR_HOURS);
    assign wr_seconds = is_write && (i_out_item.write_address == ADDR_SECONDS);
    assign wr_minutes = is_write && (i_out_item.write_address == ADDR_MINUTES);
    assign scan_ok    = (i_out_item.digit_select != 3'd0) &&
                        (i_out_item.digit_select <= 3'd4) &&
                        (i_out_item.write_data == 8'd0);

    `BCDCLK_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item), "result changed while stalled")
    `BCDCLK_ASSERT_SAME(a_single, i_clk, i_rst_n, i_out_valid && !is_write, i_out_item.last, "scan or lamp result not last")
    `BCDCLK_ASSERT_SAME(a_scan, i_clk, i_rst_n, i_out_valid && i_out_item.kind == KIND_SCAN, scan_ok, "bad scan result")
    `BCDCLK_ASSERT_NEXT(a_hours, i_clk, i_rst_n, take && wr_hours, wr_seconds && !i_out_item.last, "hours write not followed by seconds")
    `BCDCLK_ASSERT_NEXT(a_seconds, i_clk, i_rst_n, take && wr_seconds, wr_minutes && i_out_item.last, "seconds write not followed by minutes")

endmodule

bind bcd_clock_seven_segment_scanner bcdclk_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);

// ===== bench/tb_top.sv =====
// testbench of the clock display scanner: directed, back-pressure and random tests
// predicts every result word from its own copy of the clock state
// depends on bcdclk_pkg, bcdclk_if and the scanner top level
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bcdclk_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_PERCENT = 19;
    localparam logic [7:0] DIGIT_SEGS [10] = '{
        8'h0A, 8'h7B, 8'h4C, 8'h68, 8'h39, 8'hA8, 8'h88, 8'h7A, 8'h08, 8'h28
    };
    localparam logic [7:0] SEGS_BLANK = 8'hFF;
    localparam logic [7:0] SEGS_ZERO  = 8'h0A;
    localparam logic [7:0] DOT_CLEAR  = 8'hF7;

    logic i_clk;
    logic i_rst_n;

    bcdclk_in_if  in_ch ();
    bcdclk_out_if out_ch ();

    bcd_clock_seven_segment_scanner DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predicted clock state
    logic [5:0] hour_val;
    logic [7:0] minute_val;
    logic [7:0] digit_pat [4];
    logic [1:0] scan_pos;
    logic       lamp_st;

    t_out_item awaited_words [$];
    int        err_count;
    int        cycle_count;
    bit        idle_on;
    bit        hold_req;
    int        hold_left;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, awaited_words.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [7:0] seg_of(logic [3:0] nib);
        return (nib < 4'd10) ? DIGIT_SEGS[nib] : SEGS_BLANK;
    endfunction

    function automatic logic [7:0] bcd_to_bin(logic [7:0] v);
        return 8'(int'(v[7:4]) * 10 + int'(v[3:0]));
    endfunction

    function automatic logic [7:0] bin_to_bcd(logic [7:0] v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic void load_reading(logic [7:0] mins, logic [7:0] hrs);
        hour_val     = 6'(bcd_to_bin(hrs & 8'h3F));
        minute_val   = bcd_to_bin(mins);
        digit_pat[0] = seg_of({2'b00, hrs[5:4]});
        digit_pat[1] = seg_of(hrs[3:0]) & DOT_CLEAR;
        digit_pat[2] = seg_of({1'b0, mins[6:4]});
        digit_pat[3] = seg_of(mins[3:0]);
    endfunction

    function automatic void push_word(logic [1:0] kind, logic [7:0] segs, logic [2:0] sel,
                                      logic [1:0] addr, logic [7:0] data, logic fin);
        t_out_item r;
        r.kind          = kind;
        r.segments      = segs;
        r.digit_select  = sel;
        r.write_address = addr;
        r.write_data    = data;
        r.lamp_on       = lamp_st;
        r.last          = fin;
        awaited_words.push_back(r);
    endfunction

    function automatic void advance_clock(t_in_item w);
        logic [7:0] new_hrs;
        logic [1:0] pos;
        case (w.command)
            CMD_READING: load_reading(w.minutes_reg, w.hours_reg);
            CMD_ADJUST: begin
                new_hrs = w.hours_reg;
                load_reading(w.minutes_reg, w.hours_reg);
                if (minute_val >= 8'd59) begin
                    minute_val = 8'd0;
                    hour_val   = (hour_val >= 6'd23) ? 6'd0 : hour_val + 6'd1;
                    new_hrs    = bin_to_bcd({2'b00, hour_val});
                    push_word(KIND_WRITE, 8'h00, 3'd0, ADDR_HOURS, new_hrs, 1'b0);
                end else begin
                    minute_val = minute_val + 8'd1;
                end
                push_word(KIND_WRITE, 8'h00, 3'd0, ADDR_SECONDS, 8'h00, 1'b0);
                push_word(KIND_WRITE, 8'h00, 3'd0, ADDR_MINUTES, bin_to_bcd(minute_val), 1'b1);
                load_reading(bin_to_bcd(minute_val), new_hrs);
            end
            CMD_SCAN: begin
                pos = scan_pos;
                // a leading zero hour digit is not lit
                if (pos == 2'd0 && digit_pat[0] == SEGS_ZERO)
                    pos = 2'd1;
                push_word(KIND_SCAN, digit_pat[pos], {1'b0, pos} + 3'd1, ADDR_SECONDS,
                          8'h00, 1'b1);
                scan_pos = pos + 2'd1;
            end
            default: begin
                lamp_st = ~lamp_st;
                push_word(KIND_LAMP, 8'h00, 3'd0, ADDR_SECONDS, 8'h00, 1'b1);
            end
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item exp_w;
        t_out_item got_w;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_w = out_ch.item;
            if (awaited_words.size() == 0) begin
                report_mismatch("unexpected word", int'(got_w), 0);
            end else begin
                exp_w = awaited_words.pop_front();
                if (got_w.kind !== exp_w.kind)
                    report_mismatch("kind", got_w.kind, exp_w.kind);
                if (got_w.segments !== exp_w.segments)
                    report_mismatch("segments", got_w.segments, exp_w.segments);
                if (got_w.digit_select !== exp_w.digit_select)
                    report_mismatch("digit_select", got_w.digit_select, exp_w.digit_select);
                if (got_w.write_address !== exp_w.write_address)
                    report_mismatch("write_address", got_w.write_address, exp_w.write_address);
                if (got_w.write_data !== exp_w.write_data)
                    report_mismatch("write_data", got_w.write_data, exp_w.write_data);
                if (got_w.lamp_on !== exp_w.lamp_on)
                    report_mismatch("lamp_on", got_w.lamp_on, exp_w.lamp_on);
                if (got_w.last !== exp_w.last)
                    report_mismatch("last", got_w.last, exp_w.last);
            end
        end
    end

    // result side ready, with random stalls and an occasional long hold
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
            end
        end
    end

    // called just after a falling edge; returns just after a falling edge once the word has been accepted
    task automatic send_word(logic [1:0] cmd, logic [7:0] mins, logic [7:0] hrs);
        t_in_item w;
        w.command     = cmd;
        w.minutes_reg = mins;
        w.hours_reg   = hrs;
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.item  <= w;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        advance_clock(w);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_minutes();
        case ($urandom_range(0, 3))
            0, 1: return {1'b0, 3'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
            2: return 8'h59;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_hours();
        case ($urandom_range(0, 3))
            0, 1: return bin_to_bcd(8'($urandom_range(0, 23))) | {2'($urandom), 6'd0};
            2: return 8'h23;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        idle_on = 1'b1;
        // patterns straight out of reset, all segments lit
        repeat (4) send_word(CMD_SCAN, 8'h00, 8'h00);
        send_word(CMD_LAMP, 8'h00, 8'h00);
        send_word(CMD_LAMP, 8'hFF, 8'hFF);
        // minute and hour both wrap, then the leading zero is skipped
        send_word(CMD_READING, 8'h59, 8'h23);
        send_word(CMD_ADJUST, 8'h59, 8'h23);
        repeat (4) send_word(CMD_SCAN, 8'h00, 8'h00);
        send_word(CMD_ADJUST, 8'h00, 8'h00);
        send_word(CMD_ADJUST, 8'h12, 8'h09);
        // nibbles above nine give blanks and out-of-range values wrap
        send_word(CMD_READING, 8'hFF, 8'hFF);
        repeat (4) send_word(CMD_SCAN, 8'h00, 8'h00);
        send_word(CMD_ADJUST, 8'hFF, 8'hFF);
        send_word(CMD_ADJUST, 8'h58, 8'h3A);
        send_word(CMD_ADJUST, 8'h59, 8'h22);
        send_word(CMD_ADJUST, 8'hA5, 8'hC7);
    endtask

    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (20) begin
            case ($urandom_range(0, 2))
                0: send_word(CMD_SCAN, 8'($urandom), 8'($urandom));
                1: send_word(CMD_LAMP, 8'($urandom), 8'($urandom));
                default: send_word(CMD_ADJUST, pick_minutes(), pick_hours());
            endcase
        end
    endtask

    task automatic test_random(int count, bit with_idle);
        logic [1:0] cmd;
        idle_on = with_idle;
        repeat (count) begin
            cmd = 2'($urandom_range(0, 3));
            send_word(cmd, pick_minutes(), pick_hours());
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.item  = '0;
        err_count   = 0;
        cycle_count = 0;
        idle_on     = 1'b0;
        hold_req    = 1'b0;
        hold_left   = 0;
        hour_val    = '0;
        minute_val  = '0;
        scan_pos    = '0;
        lamp_st     = 1'b0;
        for (int i = 0; i < 4; i++)
            digit_pat[i] = 8'h00;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_backpressure();
        test_random(40, 1'b1);
        test_random(40, 1'b0);
        test_random(45, 1'b1);

        in_ch.valid <= 1'b0;
        idle_on = 1'b1;
        while (awaited_words.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/bcdclk_pkg.sv
hw/rtl/bcdclk_if.sv
hw/rtl/bcdclk_queue.sv
hw/rtl/bcdclk_front.sv
hw/rtl/bcdclk_back.sv
hw/rtl/bcd_clock_seven_segment_scanner.sv
hw/rtl/bcdclk_checker.sv
bench/tb_top.sv
